>>> src/mcl_pkg.sv
// ----------------------------------------------------------------------------
// mcl_pkg
// Shared sizes, codes and controller/datapath interface types for the
// multiplex code channel lookup block.
// ----------------------------------------------------------------------------
package mcl_pkg;

  localparam int NUM_CODES    = 16;
  localparam int FIXED_DEPTH  = 256;
  localparam int REPEAT_DEPTH = 64;

  localparam int FUNC_W   = 2;
  localparam int CODE_W   = 4;
  localparam int CHAN_W   = 8;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;

  localparam int CODE_IDX_W = $clog2(NUM_CODES);
  localparam int FL_W       = $clog2(FIXED_DEPTH + 1);
  localparam int RL_W       = $clog2(REPEAT_DEPTH + 1);
  localparam int FIX_AW     = $clog2(NUM_CODES * FIXED_DEPTH);
  localparam int REP_AW     = $clog2(NUM_CODES * REPEAT_DEPTH);

  // restoring remainder: one dividend bit per step
  localparam int DIV_STEPS = POS_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [FUNC_W-1:0] {
    FN_DEFINE     = 2'd0,
    FN_APPEND_FIX = 2'd1,
    FN_APPEND_REP = 2'd2,
    FN_LOOKUP     = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNSET     = 2'd1,
    ST_NO_REPEAT = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RT_DIRECT = 2'd0,
    RT_FIXED  = 2'd1,
    RT_REPEAT = 2'd2
  } route_e;

  typedef struct packed {
    logic load;
    logic update;
    logic set_res;
    logic div_init;
    logic div_step;
    logic mem_rd;
  } mcl_cmd_t;

  typedef struct packed {
    route_e route;
    logic   div_last;
  } mcl_stat_t;

endpackage

>>> src/mcl_datapath.sv
// ----------------------------------------------------------------------------
// mcl_datapath
// Item registers, per-code length table, slot memories and the iterative
// remainder unit of the multiplex code channel lookup.
// ----------------------------------------------------------------------------
module mcl_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mcl_pkg::mcl_cmd_t           cmd_i,
  output mcl_pkg::mcl_stat_t          stat_o,
  input  logic [mcl_pkg::FUNC_W-1:0]  func_i,
  input  logic [mcl_pkg::CODE_W-1:0]  code_i,
  input  logic [mcl_pkg::CHAN_W-1:0]  channel_i,
  input  logic [mcl_pkg::POS_W-1:0]   position_i,
  output logic [mcl_pkg::CHAN_W-1:0]  channel_out_o,
  output logic [mcl_pkg::STATUS_W-1:0] status_o
);

  // latched item
  mcl_pkg::func_e             func_q;
  logic [mcl_pkg::CODE_W-1:0] code_q;
  logic [mcl_pkg::CHAN_W-1:0] chan_q;
  logic [mcl_pkg::POS_W-1:0]  pos_q;

  // per-code table
  logic                      valid_q [mcl_pkg::NUM_CODES];
  logic [mcl_pkg::FL_W-1:0]  fl_q    [mcl_pkg::NUM_CODES];
  logic [mcl_pkg::RL_W-1:0]  rl_q    [mcl_pkg::NUM_CODES];

  // slot memories
  logic [mcl_pkg::CHAN_W-1:0] fix_mem [mcl_pkg::NUM_CODES * mcl_pkg::FIXED_DEPTH];
  logic [mcl_pkg::CHAN_W-1:0] rep_mem [mcl_pkg::NUM_CODES * mcl_pkg::REPEAT_DEPTH];
  logic [mcl_pkg::CHAN_W-1:0] fix_rd_q;
  logic [mcl_pkg::CHAN_W-1:0] rep_rd_q;

  // remainder unit
  logic [mcl_pkg::POS_W-1:0] dvd_q;
  logic [mcl_pkg::RL_W-1:0]  rem_q;
  logic [mcl_pkg::CNT_W-1:0] cnt_q;
  logic [mcl_pkg::RL_W:0]    trial;
  logic [mcl_pkg::RL_W:0]    divisor;

  // result
  mcl_pkg::route_e  res_src_q;
  mcl_pkg::status_e status_q;

  logic [mcl_pkg::CODE_IDX_W-1:0] idx;
  logic                     code_ok;
  logic                     cur_valid;
  logic [mcl_pkg::FL_W-1:0] cur_fl;
  logic [mcl_pkg::RL_W-1:0] cur_rl;
  mcl_pkg::route_e          route;
  mcl_pkg::status_e         st;
  logic                     do_def;
  logic                     do_fix;
  logic                     do_rep;
  logic [mcl_pkg::FIX_AW-1:0] fix_wa;
  logic [mcl_pkg::FIX_AW-1:0] fix_ra;
  logic [mcl_pkg::REP_AW-1:0] rep_wa;
  logic [mcl_pkg::REP_AW-1:0] rep_ra;

  assign idx       = code_q[mcl_pkg::CODE_IDX_W-1:0];
  assign code_ok   = 32'(code_q) < mcl_pkg::NUM_CODES;
  assign cur_valid = valid_q[idx];
  assign cur_fl    = fl_q[idx];
  assign cur_rl    = rl_q[idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= mcl_pkg::func_e'(func_i);
      code_q <= code_i;
      chan_q <= channel_i;
      pos_q  <= position_i;
    end
  end

  // decode of the latched item against the table
  always_comb begin
    route  = mcl_pkg::RT_DIRECT;
    st     = mcl_pkg::ST_OK;
    do_def = 1'b0;
    do_fix = 1'b0;
    do_rep = 1'b0;
    if (!code_ok) begin
      st = mcl_pkg::ST_UNSET;
    end else if (func_q == mcl_pkg::FN_DEFINE) begin
      do_def = 1'b1;
    end else if (!cur_valid) begin
      st = mcl_pkg::ST_UNSET;
    end else begin
      case (func_q)
        mcl_pkg::FN_APPEND_FIX: begin
          if (cur_fl >= mcl_pkg::FL_W'(mcl_pkg::FIXED_DEPTH)) st = mcl_pkg::ST_FULL;
          else do_fix = 1'b1;
        end
        mcl_pkg::FN_APPEND_REP: begin
          if (cur_rl >= mcl_pkg::RL_W'(mcl_pkg::REPEAT_DEPTH)) st = mcl_pkg::ST_FULL;
          else do_rep = 1'b1;
        end
        mcl_pkg::FN_LOOKUP: begin
          if (pos_q < mcl_pkg::POS_W'(cur_fl)) route = mcl_pkg::RT_FIXED;
          else if (cur_rl == '0) st = mcl_pkg::ST_NO_REPEAT;
          else route = mcl_pkg::RT_REPEAT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcl_pkg::NUM_CODES; i++) begin
        valid_q[i] <= 1'b0;
        fl_q[i]    <= '0;
        rl_q[i]    <= '0;
      end
    end else if (cmd_i.update) begin
      if (do_def) begin
        valid_q[idx] <= 1'b1;
        fl_q[idx]    <= '0;
        rl_q[idx]    <= '0;
      end
      if (do_fix) fl_q[idx] <= cur_fl + 1'b1;
      if (do_rep) rl_q[idx] <= cur_rl + 1'b1;
    end
  end

  assign fix_wa = mcl_pkg::FIX_AW'(idx) * mcl_pkg::FIX_AW'(mcl_pkg::FIXED_DEPTH)
                + mcl_pkg::FIX_AW'(cur_fl);
  assign fix_ra = mcl_pkg::FIX_AW'(idx) * mcl_pkg::FIX_AW'(mcl_pkg::FIXED_DEPTH)
                + mcl_pkg::FIX_AW'(pos_q);
  assign rep_wa = mcl_pkg::REP_AW'(idx) * mcl_pkg::REP_AW'(mcl_pkg::REPEAT_DEPTH)
                + mcl_pkg::REP_AW'(cur_rl);
  assign rep_ra = mcl_pkg::REP_AW'(idx) * mcl_pkg::REP_AW'(mcl_pkg::REPEAT_DEPTH)
                + mcl_pkg::REP_AW'(rem_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && do_fix) fix_mem[fix_wa] <= chan_q;
    if (cmd_i.mem_rd && res_src_q == mcl_pkg::RT_FIXED) fix_rd_q <= fix_mem[fix_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && do_rep) rep_mem[rep_wa] <= chan_q;
    if (cmd_i.mem_rd && res_src_q == mcl_pkg::RT_REPEAT) rep_rd_q <= rep_mem[rep_ra];
  end

  // (position - fixed length) mod repeat length, MSB first
  assign divisor = {1'b0, cur_rl};
  assign trial   = {rem_q, dvd_q[mcl_pkg::POS_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q <= pos_q - mcl_pkg::POS_W'(cur_fl);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[mcl_pkg::POS_W-2:0], 1'b0};
      if (trial >= divisor) rem_q <= mcl_pkg::RL_W'(trial - divisor);
      else rem_q <= trial[mcl_pkg::RL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_src_q <= mcl_pkg::RT_DIRECT;
      status_q  <= mcl_pkg::ST_OK;
    end else if (cmd_i.set_res) begin
      res_src_q <= route;
      status_q  <= st;
    end
  end

  always_comb begin
    case (res_src_q)
      mcl_pkg::RT_FIXED:  channel_out_o = fix_rd_q;
      mcl_pkg::RT_REPEAT: channel_out_o = rep_rd_q;
      default:            channel_out_o = '0;
    endcase
  end

  assign status_o        = status_q;
  assign stat_o.route    = route;
  assign stat_o.div_last = cnt_q == mcl_pkg::CNT_W'(mcl_pkg::DIV_STEPS - 1);

endmodule

>>> src/mcl_ctrl.sv
// ----------------------------------------------------------------------------
// mcl_ctrl
// Sequencer for the multiplex code channel lookup: accept, evaluate,
// remainder loop, slot read and result strobe.
// ----------------------------------------------------------------------------
module mcl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  mcl_pkg::mcl_stat_t stat_i,
  output mcl_pkg::mcl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DIV  = 5'b00100,
    S_RD   = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        // table update and result status happen here for every item
        cmd_o.update  = 1'b1;
        cmd_o.set_res = 1'b1;
        case (stat_i.route)
          mcl_pkg::RT_FIXED:  state_d = S_RD;
          mcl_pkg::RT_REPEAT: begin
            cmd_o.div_init = 1'b1;
            state_d        = S_DIV;
          end
          default:            state_d = S_RESP;
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_RD;
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_RESP;

endmodule

>>> src/mux_code_channel_lookup_top.sv
// ----------------------------------------------------------------------------
// mux_code_channel_lookup_top
// Table of multiplex codes with fixed and repeating channel sequences and a
// byte-position to logical-channel lookup.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its single result
// appears on channel_out_o/status_o for exactly one cycle with done_o high,
// and the receiver cannot stall it. Define, append and failed lookups pass
// from evaluation straight to the strobe; a lookup that hits the fixed part
// does a slot read first. A lookup into the repeat part runs a 16-step
// remainder loop (one dividend bit per cycle), then the slot read. busy_o
// drops the cycle after done_o; a new item waits until the last one is done.
// Table valid flags and lengths clear at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mux_code_channel_lookup_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [mcl_pkg::FUNC_W-1:0]   func_i,
  input  logic [mcl_pkg::CODE_W-1:0]   code_i,
  input  logic [mcl_pkg::CHAN_W-1:0]   channel_i,
  input  logic [mcl_pkg::POS_W-1:0]    position_i,
  output logic                         done_o,
  output logic [mcl_pkg::CHAN_W-1:0]   channel_out_o,
  output logic [mcl_pkg::STATUS_W-1:0] status_o
);

  mcl_pkg::mcl_cmd_t  cmd;
  mcl_pkg::mcl_stat_t stat;

  mcl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  mcl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (func_i),
    .code_i        (code_i),
    .channel_i     (channel_i),
    .position_i    (position_i),
    .channel_out_o (channel_out_o),
    .status_o      (status_o)
  );

  // an accepted transfer always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // the result strobe ends the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("block still busy after result strobe");

  // a failed item never reports a channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != mcl_pkg::ST_OK |-> channel_out_o == '0)
    else $error("nonzero channel with error status");

  // remainder loop only runs while busy and never during the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> busy_o && !done_o)
    else $error("remainder step outside an item");

endmodule
